>>> design/assert_macros.svh
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define TMSN_ASSERT(name, clk, rst, prop) \
   name: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define TMSN_ASSERT_NEVER(name, clk, rst, expr) \
   name: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("forbidden condition seen");
`else
`define TMSN_ASSERT(name, clk, rst, prop)
`define TMSN_ASSERT_NEVER(name, clk, rst, expr)
`endif
`endif

>>> design/tmsn_pkg.sv
`default_nettype none
package tmsn_pkg;

   localparam int TRIM_COUNT_DEF = 10;
   localparam int CHANNELS_DEF   = 8;

   localparam int CH_W       = 3;
   localparam int SAMPLE_W   = 12;
   localparam int SUM_W      = 16;
   localparam int CNT_W      = 4;
   localparam int GAIN_W     = 10;
   localparam int FS_W       = 13;
   localparam int CLAMP_W    = 10;
   localparam int NORM_W     = 10;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 13;

   localparam int PROD_W    = SAMPLE_W + GAIN_W;
   localparam int DIV_STEPS = PROD_W;
   localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

   localparam logic [GAIN_W-1:0]   GAIN_RESET  = GAIN_W'(100);
   localparam logic [FS_W-1:0]     FS_RESET    = FS_W'(4095);
   localparam logic [CLAMP_W-1:0]  CLAMP_RESET = CLAMP_W'(210);
   localparam logic [SAMPLE_W-1:0] MIN_RESET   = SAMPLE_W'(4095);

   typedef struct packed {
      logic accept;
      logic trim_load;
      logic div_load_norm;
      logic div_step;
      logic mean_cap;
      logic out_load;
   } tmsn_cmd_type;

   typedef struct packed {
      logic group_done;
      logic div_last;
      logic fs_zero;
      logic out_free;
   } tmsn_sts_type;

endpackage
`default_nettype wire

>>> design/tmsn_controller.sv
`default_nettype none
module tmsn_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  tmsn_pkg::tmsn_sts_type sts,
   output tmsn_pkg::tmsn_cmd_type cmd
);
   import tmsn_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE      = 5'b00001,
      S_MEAN_CAP  = 5'b00010,
      S_NORM_LOAD = 5'b00100,
      S_DIV_NORM  = 5'b01000,
      S_EMIT      = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            cmd.accept = req_valid;
            if (req_valid && sts.group_done) begin
               cmd.trim_load = 1'b1;
               state_in      = S_MEAN_CAP;
            end
         end
         S_MEAN_CAP: begin
            cmd.mean_cap = 1'b1;
            state_in     = S_NORM_LOAD;
         end
         S_NORM_LOAD: begin
            if (sts.fs_zero) begin
               state_in = S_EMIT;
            end else begin
               cmd.div_load_norm = 1'b1;
               state_in          = S_DIV_NORM;
            end
         end
         S_DIV_NORM: begin
            cmd.div_step = 1'b1;
            if (sts.div_last) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule
`default_nettype wire

>>> design/tmsn_datapath.sv
`default_nettype none
`include "assert_macros.svh"
module tmsn_datapath #(
   parameter int TRIM_COUNT = tmsn_pkg::TRIM_COUNT_DEF,
   parameter int CHANNELS   = tmsn_pkg::CHANNELS_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  tmsn_pkg::tmsn_cmd_type            cmd,
   output tmsn_pkg::tmsn_sts_type            sts,
   input  logic [tmsn_pkg::CH_W-1:0]         req_channel,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]     req_sample,
   input  logic                              csr_valid,
   input  logic [tmsn_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tmsn_pkg::CSR_DATA_W-1:0]   csr_wdata,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [tmsn_pkg::CH_W-1:0]         rsp_out_channel,
   output logic [tmsn_pkg::SAMPLE_W-1:0]     rsp_mean_value,
   output logic [tmsn_pkg::NORM_W-1:0]       rsp_normalized
);
   import tmsn_pkg::*;

   localparam int DEPTH = (CHANNELS < (1 << CH_W)) ? CHANNELS : (1 << CH_W);
   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [CNT_W-1:0] GROUP_LEN = CNT_W'(TRIM_COUNT + 2);

   // The trimmed sum is divided by TRIM_COUNT through a multiplication by a rounded-up
   // reciprocal, which is exact for every dividend of SUM_W bits.
   localparam int MEAN_SHIFT  = SUM_W + $clog2(TRIM_COUNT);
   localparam int MEAN_PROD_W = 2 * SUM_W + 1;
   localparam int MEAN_TOP    = MEAN_SHIFT + SAMPLE_W;
   localparam logic [SUM_W:0] MEAN_RECIP =
      (SUM_W + 1)'(((1 << MEAN_SHIFT) + TRIM_COUNT - 1) / TRIM_COUNT);

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN       = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_FULL_SCALE = CSR_IDX_W'(1);
   localparam logic [CSR_IDX_W-1:0] CSR_CLAMP_HIGH = CSR_IDX_W'(2);

   logic [GAIN_W-1:0]  gain_ff;
   logic [FS_W-1:0]    fs_ff;
   logic [CLAMP_W-1:0] clamp_ff;

   logic [SUM_W-1:0]    sum_ff [DEPTH];
   logic [SAMPLE_W-1:0] max_ff [DEPTH];
   logic [SAMPLE_W-1:0] min_ff [DEPTH];
   logic [CNT_W-1:0]    cnt_ff [DEPTH];

   logic                ch_valid;
   logic [IDX_W-1:0]    idx;
   logic [SUM_W-1:0]    sum_in;
   logic [SAMPLE_W-1:0] max_in;
   logic [SAMPLE_W-1:0] min_in;
   logic [CNT_W-1:0]    cnt_in;
   logic                complete;
   logic [SUM_W-1:0]    trimmed;

   logic [SUM_W-1:0]       trim_ff;
   logic [MEAN_PROD_W-1:0] mean_prod;

   logic [PROD_W-1:0]    quo_ff;
   logic [FS_W-1:0]      rem_ff;
   logic [FS_W-1:0]      den_ff;
   logic [DIV_CNT_W-1:0] dcnt_ff;
   logic [FS_W:0]        rem_sh;
   logic [FS_W:0]        diff;
   logic                 ge;

   logic [CH_W-1:0]     chan_ff;
   logic [SAMPLE_W-1:0] mean_ff;
   logic [NORM_W-1:0]   norm_value;

   logic                rsp_valid_ff;
   logic [CH_W-1:0]     rsp_channel_ff;
   logic [SAMPLE_W-1:0] rsp_mean_ff;
   logic [NORM_W-1:0]   rsp_norm_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff  <= GAIN_RESET;
         fs_ff    <= FS_RESET;
         clamp_ff <= CLAMP_RESET;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:       gain_ff  <= csr_wdata[GAIN_W-1:0];
            CSR_FULL_SCALE: fs_ff    <= csr_wdata[FS_W-1:0];
            CSR_CLAMP_HIGH: clamp_ff <= csr_wdata[CLAMP_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      ch_valid = ({1'b0, req_channel} < (CH_W + 1)'(DEPTH));
      idx      = req_channel[IDX_W-1:0];
      sum_in   = sum_ff[idx] + SUM_W'(req_sample);
      max_in   = (req_sample > max_ff[idx]) ? req_sample : max_ff[idx];
      min_in   = (req_sample < min_ff[idx]) ? req_sample : min_ff[idx];
      cnt_in   = cnt_ff[idx] + CNT_W'(1);
      complete = ch_valid && (cnt_in >= GROUP_LEN);
      trimmed  = sum_in - SUM_W'(max_in) - SUM_W'(min_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            sum_ff[i] <= '0;
            max_ff[i] <= '0;
            min_ff[i] <= MIN_RESET;
            cnt_ff[i] <= '0;
         end
      end else if (cmd.accept && ch_valid) begin
         if (complete) begin
            sum_ff[idx] <= '0;
            max_ff[idx] <= '0;
            min_ff[idx] <= MIN_RESET;
            cnt_ff[idx] <= '0;
         end else begin
            sum_ff[idx] <= sum_in;
            max_ff[idx] <= max_in;
            min_ff[idx] <= min_in;
            cnt_ff[idx] <= cnt_in;
         end
      end
   end

   always_comb begin
      mean_prod = MEAN_PROD_W'(trim_ff) * MEAN_PROD_W'(MEAN_RECIP);
   end

   // Restoring divider for the normalisation, one quotient bit per cycle.
   always_comb begin
      rem_sh = {rem_ff, quo_ff[PROD_W-1]};
      diff   = rem_sh - {1'b0, den_ff};
      ge     = (rem_sh >= {1'b0, den_ff});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dcnt_ff <= '0;
      end else if (cmd.div_load_norm) begin
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         dcnt_ff <= dcnt_ff + DIV_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.div_load_norm) begin
         quo_ff <= PROD_W'(mean_ff) * PROD_W'(gain_ff);
         rem_ff <= '0;
         den_ff <= fs_ff;
      end else if (cmd.div_step) begin
         quo_ff <= {quo_ff[PROD_W-2:0], ge};
         rem_ff <= ge ? diff[FS_W-1:0] : rem_sh[FS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.trim_load) begin
         chan_ff <= req_channel;
         trim_ff <= trimmed;
      end
      if (cmd.mean_cap) begin
         mean_ff <= mean_prod[MEAN_SHIFT +: SAMPLE_W];
      end
   end

   always_comb begin
      if (fs_ff == '0) begin
         norm_value = NORM_W'(clamp_ff);
      end else if (quo_ff > PROD_W'(clamp_ff)) begin
         norm_value = NORM_W'(clamp_ff);
      end else begin
         norm_value = quo_ff[NORM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_channel_ff <= chan_ff;
         rsp_mean_ff    <= mean_ff;
         rsp_norm_ff    <= norm_value;
      end
   end

   assign sts.group_done = complete;
   assign sts.div_last   = (dcnt_ff == DIV_CNT_W'(DIV_STEPS - 1));
   assign sts.fs_zero    = (fs_ff == '0);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_channel = rsp_channel_ff;
   assign rsp_mean_value  = rsp_mean_ff;
   assign rsp_normalized  = rsp_norm_ff;

   `TMSN_ASSERT(a_load_only_when_free, clock, reset, cmd.out_load |-> sts.out_free)
   `TMSN_ASSERT_NEVER(a_div_overrun, clock, reset, cmd.div_step && (dcnt_ff >= DIV_CNT_W'(DIV_STEPS)))
   `TMSN_ASSERT(a_mean_fits, clock, reset, cmd.mean_cap |-> (mean_prod[MEAN_PROD_W-1:MEAN_TOP] == '0))
   `TMSN_ASSERT(a_norm_clamped, clock, reset, rsp_valid_ff |-> (rsp_norm_ff <= NORM_W'(clamp_ff)))

endmodule
`default_nettype wire

>>> design/trimmed_mean_sensor_normalizer.sv
`default_nettype none
// A sample that completes a group gives its result after the mean capture, the division
// for the normalisation and the output load; the division is skipped when full_scale is
// zero. Other samples are taken one per cycle; a completing one holds the input until its
// result is loaded, plus any output stall. The restoring divider yields one bit per cycle.
// Reset is synchronous: the configuration registers return to their defaults and all channels are cleared.
module trimmed_mean_sensor_normalizer #(
   parameter int TRIM_COUNT = tmsn_pkg::TRIM_COUNT_DEF,
   parameter int CHANNELS   = tmsn_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [tmsn_pkg::CH_W-1:0]       req_channel,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [tmsn_pkg::CH_W-1:0]       rsp_out_channel,
   output logic [tmsn_pkg::SAMPLE_W-1:0]   rsp_mean_value,
   output logic [tmsn_pkg::NORM_W-1:0]     rsp_normalized,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [tmsn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmsn_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import tmsn_pkg::*;

   tmsn_cmd_type cmd;
   tmsn_sts_type sts;

   assign csr_ready = 1'b1;

   tmsn_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   tmsn_datapath #(
      .TRIM_COUNT (TRIM_COUNT),
      .CHANNELS   (CHANNELS)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .csr_valid       (csr_valid),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_normalized  (rsp_normalized)
   );

endmodule
`default_nettype wire

>>> sim/tmsn_tb_pkg.sv
package tmsn_tb_pkg;

   typedef enum logic [tmsn_pkg::CSR_IDX_W-1:0] {
      CSR_GAIN       = 2'd0,
      CSR_FULL_SCALE = 2'd1,
      CSR_CLAMP_HIGH = 2'd2,
      CSR_SPARE      = 2'd3
   } csr_reg_type;

endpackage

>>> sim/tmsn_checker.sv
module tmsn_checker #(
   parameter int TRIM_COUNT = tmsn_pkg::TRIM_COUNT_DEF,
   parameter int CHANNELS   = tmsn_pkg::CHANNELS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_stall,
   input  logic [tmsn_pkg::CH_W-1:0]       req_channel,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   req_sample,
   input  logic                            rsp_valid,
   input  logic                            rsp_stall,
   input  logic [tmsn_pkg::CH_W-1:0]       rsp_out_channel,
   input  logic [tmsn_pkg::SAMPLE_W-1:0]   rsp_mean_value,
   input  logic [tmsn_pkg::NORM_W-1:0]     rsp_normalized,
   input  logic                            csr_valid,
   input  logic                            csr_ready,
   input  logic [tmsn_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tmsn_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              errors,
   output int                              pending,
   output int                              groups_checked
);
   import tmsn_pkg::*;
   import tmsn_tb_pkg::*;

   typedef struct packed {
      logic [CH_W-1:0]     out_channel;
      logic [SAMPLE_W-1:0] mean_value;
      logic [NORM_W-1:0]   normalized;
   } group_result_type;

   group_result_type awaited_groups[$];

   logic [GAIN_W-1:0]   gain_q;
   logic [FS_W-1:0]     full_scale_q;
   logic [CLAMP_W-1:0]  clamp_q;

   logic [SUM_W-1:0]    group_total [CHANNELS];
   logic [SAMPLE_W-1:0] group_peak  [CHANNELS];
   logic [SAMPLE_W-1:0] group_floor [CHANNELS];
   logic [CNT_W-1:0]    group_fill  [CHANNELS];

   int error_tally = 0;
   int compared_tally = 0;
   group_result_type oldest;

   task automatic clear_group(input int idx);
      group_total[idx] = '0;
      group_peak[idx]  = '0;
      group_floor[idx] = MIN_RESET;
      group_fill[idx]  = '0;
   endtask

   // Folds one sample into its channel and, when the group is full, queues the trimmed
   // and normalised result that the block must produce.
   task automatic absorb_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
      int unsigned idx;
      int unsigned trimmed;
      int unsigned mean;
      int unsigned scaled;
      group_result_type outcome;
      idx = ch;
      if (idx >= CHANNELS) return;
      group_total[idx] = group_total[idx] + SUM_W'(value);
      if (value > group_peak[idx]) group_peak[idx] = value;
      if (value < group_floor[idx]) group_floor[idx] = value;
      group_fill[idx] = group_fill[idx] + 1'b1;
      if (group_fill[idx] < TRIM_COUNT + 2) return;
      trimmed = group_total[idx] - group_peak[idx] - group_floor[idx];
      mean = (trimmed / TRIM_COUNT) & 32'hFFF;
      if (full_scale_q == '0) begin
         scaled = clamp_q;
      end else begin
         scaled = (mean * gain_q) / full_scale_q;
         if (scaled > clamp_q) scaled = clamp_q;
      end
      outcome.out_channel = ch;
      outcome.mean_value  = SAMPLE_W'(mean);
      outcome.normalized  = NORM_W'(scaled);
      awaited_groups.push_back(outcome);
      clear_group(idx);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         gain_q       = GAIN_RESET;
         full_scale_q = FS_RESET;
         clamp_q      = CLAMP_RESET;
         for (int i = 0; i < CHANNELS; i++) clear_group(i);
         awaited_groups.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_groups.size() == 0) begin
               $display("%0t: result transaction with none expected: channel %0d mean %0d norm %0d",
                        $time, rsp_out_channel, rsp_mean_value, rsp_normalized);
               error_tally++;
            end else begin
               oldest = awaited_groups.pop_front();
               compared_tally++;
               if (rsp_out_channel !== oldest.out_channel) begin
                  $display("%0t: out_channel expected %0d, actual %0d",
                           $time, oldest.out_channel, rsp_out_channel);
                  error_tally++;
               end
               if (rsp_mean_value !== oldest.mean_value) begin
                  $display("%0t: mean_value expected %0d, actual %0d",
                           $time, oldest.mean_value, rsp_mean_value);
                  error_tally++;
               end
               if (rsp_normalized !== oldest.normalized) begin
                  $display("%0t: normalized expected %0d, actual %0d",
                           $time, oldest.normalized, rsp_normalized);
                  error_tally++;
               end
            end
         end
         if (req_valid && !req_stall) absorb_sample(req_channel, req_sample);
         if (csr_valid && csr_ready) begin
            case (csr_reg_type'(csr_index))
               CSR_GAIN:       gain_q       = csr_wdata[GAIN_W-1:0];
               CSR_FULL_SCALE: full_scale_q = csr_wdata[FS_W-1:0];
               CSR_CLAMP_HIGH: clamp_q      = csr_wdata[CLAMP_W-1:0];
               default: ;
            endcase
         end
      end
      pending        <= awaited_groups.size();
      errors         <= error_tally;
      groups_checked <= compared_tally;
   end

endmodule

>>> sim/tb.sv
module tb;
   import tmsn_pkg::*;
   import tmsn_tb_pkg::*;

   localparam int RANDOM_PHASES   = 8;
   localparam int ITEMS_PER_PHASE = 250;
   localparam int SETTLE_CYCLES   = 64;
   localparam int CYCLE_LIMIT     = 600000;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [CH_W-1:0]       req_channel = '0;
   logic [SAMPLE_W-1:0]   req_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [CH_W-1:0]       rsp_out_channel;
   logic [SAMPLE_W-1:0]   rsp_mean_value;
   logic [NORM_W-1:0]     rsp_normalized;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   int errors;
   int pending;
   int groups_checked;
   int cycle_count = 0;
   int req_gap_max = 3;
   int rsp_gap_max = 3;
   int rsp_hold = 0;
   int rsp_draw;
   int samples_sent = 0;

   always #5 clock = ~clock;

   trimmed_mean_sensor_normalizer dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_normalized  (rsp_normalized),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   tmsn_checker chk (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_channel     (req_channel),
      .req_sample      (req_sample),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_channel (rsp_out_channel),
      .rsp_mean_value  (rsp_mean_value),
      .rsp_normalized  (rsp_normalized),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .errors          (errors),
      .pending         (pending),
      .groups_checked  (groups_checked)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("FAILURE");
         $finish;
      end
   end

   // After each accepted result transaction the receiver holds off for a random count.
   always @(posedge clock) begin
      if (rsp_valid && !rsp_stall) begin
         rsp_draw = $urandom_range(0, rsp_gap_max);
         rsp_hold <= rsp_draw;
         rsp_stall <= (rsp_draw != 0);
      end else if (rsp_hold != 0) begin
         rsp_hold <= rsp_hold - 1;
         rsp_stall <= (rsp_hold > 1);
      end
   end

   task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] value);
      int gap;
      gap = $urandom_range(0, req_gap_max);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_channel <= ch;
      req_sample  <= value;
      do @(posedge clock); while (req_stall);
      samples_sent++;
   endtask

   task automatic write_reg(input csr_reg_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic [SAMPLE_W-1:0] pick_sample();
      case ($urandom_range(0, 4))
         0:       return SAMPLE_W'($urandom_range(0, 7));
         1:       return SAMPLE_W'(4095 - $urandom_range(0, 7));
         2:       return SAMPLE_W'($urandom_range(1900, 2200));
         default: return SAMPLE_W'($urandom_range(0, 4095));
      endcase
   endfunction

   initial begin
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Two interleaved groups: one with both extremes present, one with the peak
      // in the middle and the floor as the final sample.
      for (int i = 0; i < TRIM_COUNT_DEF + 2; i++) begin
         send_sample(CH_W'(7), (i == 1) ? SAMPLE_W'(0) : SAMPLE_W'(4095));
         send_sample(CH_W'(0), (i == 5) ? SAMPLE_W'(4095) :
                               (i == TRIM_COUNT_DEF + 1) ? SAMPLE_W'(0) : SAMPLE_W'(2000));
      end
      drain();

      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         case (phase)
            0: ;
            1: begin
               write_reg(CSR_GAIN, 13'd1023);
               write_reg(CSR_FULL_SCALE, 13'd1);
               write_reg(CSR_CLAMP_HIGH, 13'd1023);
            end
            2: begin
               write_reg(CSR_GAIN, 13'd0);
               write_reg(CSR_FULL_SCALE, 13'd4096);
               write_reg(CSR_CLAMP_HIGH, 13'd0);
            end
            3: begin
               write_reg(CSR_GAIN, 13'd1023);
               write_reg(CSR_FULL_SCALE, 13'd0);
               write_reg(CSR_CLAMP_HIGH, 13'd517);
               write_reg(CSR_SPARE, 13'h1FFF);
            end
            4: begin
               write_reg(CSR_GAIN, 13'd512);
               write_reg(CSR_FULL_SCALE, 13'd4096);
               write_reg(CSR_CLAMP_HIGH, 13'd1023);
            end
            default: begin
               write_reg(CSR_GAIN, CSR_DATA_W'($urandom_range(0, 8191)));
               write_reg(CSR_FULL_SCALE, CSR_DATA_W'($urandom_range(0, 8191)));
               write_reg(CSR_CLAMP_HIGH, CSR_DATA_W'($urandom_range(0, 8191)));
            end
         endcase
         if (phase != 0) csr_valid <= 1'b0;
         req_gap_max = (phase == 2 || phase == 5) ? 0 : 3;
         rsp_gap_max = (phase == 2 || phase == 5) ? 0 : 3;
         for (int n = 0; n < ITEMS_PER_PHASE; n++)
            send_sample(CH_W'($urandom_range(0, 7)), pick_sample());
         drain();
      end

      $display("Drove %0d samples over eight channels under %0d register settings.",
               samples_sent, RANDOM_PHASES);
      $display("Compared %0d completed groups, with clamping and zero full scale among them.",
               groups_checked);
      if (errors == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

>>> files.f
+incdir+design
design/tmsn_pkg.sv
design/tmsn_controller.sv
design/tmsn_datapath.sv
design/trimmed_mean_sensor_normalizer.sv
sim/tmsn_tb_pkg.sv
sim/tmsn_checker.sv
sim/tb.sv
